FILE: hdl/pscf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pscf_pkg: shared types and constants for the parameter store
// Item kinds, controller states, the controller/datapath command and status
// words, and the byte-wise CRC-32 step.
// ----------------------------------------------------------------------------
package pscf_pkg;

    localparam int PSCF_PARAM_COUNT = 8;

    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    localparam logic REPLY_LOAD  = 1'b0;
    localparam logic REPLY_IMAGE = 1'b1;

    typedef enum logic [1:0] {
        KIND_SAVE = 2'd0,
        KIND_LOAD = 2'd1,
        KIND_TICK = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_FL_READ,
        ST_FL_CRC,
        ST_FL_END
    } state_t;

    typedef struct packed {
        logic save;        // write the table, set dirty
        logic load_cap;    // capture slot number of a load
        logic load_emit;   // drive the load reply
        logic flush_init;  // clear dirty, seed CRC, rewind pointer
        logic use_ptr;     // table read address from the flush pointer
        logic crc_step;    // fold one byte of the current word
        logic emit_crc;    // drive the CRC word
    } pscf_cmd_t;

    typedef struct packed {
        logic in_range;
        logic dirty;
        logic byte_last;
        logic ptr_last;
    } pscf_stat_t;

    // reflected CRC-32 over one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
        logic [31:0] c;
        c = crc ^ {24'h0, data};
        for (int b = 0; b < 8; b++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'h0);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/param_store_crc32_flush.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// param_store_crc32_flush: parameter table with CRC-32 flash image flush
// A word is taken when start is high and busy is low. kind selects save,
// load or flush tick. Out-of-range slots, unused kinds and ticks with a
// clean table are dropped without a result; for such a word and a save
// the controller stays idle and busy never rises.
// A load answers with one result word, registered out of ST_LOAD.
// A dirty tick emits PARAM_COUNT data words and then the CRC-32 word
// (last_word high). The table is read one slot per read cycle and the
// CRC engine folds one byte per cycle; busy stays high through the whole
// flush, from ST_FL_READ to the CRC word in ST_FL_END.
// Results appear for one cycle with strobe high; the receiver cannot
// stall them, and none is held back.
// Reset clears the control state and the slot valid bits, so every slot
// reads as zero and the dirty flag is clear; no clearing pass is needed.
// ----------------------------------------------------------------------------
module param_store_crc32_flush
    import pscf_pkg::*;
#(
    parameter int PARAM_COUNT = PSCF_PARAM_COUNT
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  kind,
    input  wire logic [7:0]  param_index,
    input  wire logic [31:0] param_value,
    output logic             strobe,
    output logic             reply_kind,
    output logic [6:0]       word_index,
    output logic [31:0]      word_value,
    output logic             last_word
);

    pscf_cmd_t  cmd;
    pscf_stat_t stat;

    pscf_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .kind  (kind),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    pscf_datapath #(
        .PARAM_COUNT (PARAM_COUNT)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .param_index (param_index),
        .param_value (param_value),
        .strobe      (strobe),
        .reply_kind  (reply_kind),
        .word_index  (word_index),
        .word_value  (word_value),
        .last_word   (last_word)
    );

endmodule
`default_nettype wire

FILE: hdl/pscf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pscf_ctrl: sequencer for the parameter store
// Decodes accepted words and steps the flush through read, CRC and end.
// ----------------------------------------------------------------------------
module pscf_ctrl
    import pscf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic [1:0] kind,
    input  wire pscf_stat_t stat,
    output pscf_cmd_t       cmd,
    output logic            busy
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    case (kind)
                        KIND_SAVE:
                        begin
                            cmd.save = stat.in_range;
                        end
                        KIND_LOAD:
                        begin
                            if (stat.in_range)
                            begin
                                cmd.load_cap = 1'b1;
                                state_next   = ST_LOAD;
                            end
                        end
                        KIND_TICK:
                        begin
                            if (stat.dirty)
                            begin
                                cmd.flush_init = 1'b1;
                                state_next     = ST_FL_READ;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_LOAD:
            begin
                cmd.load_emit = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_FL_READ:
            begin
                cmd.use_ptr = 1'b1;
                state_next  = ST_FL_CRC;
            end
            ST_FL_CRC:
            begin
                cmd.use_ptr  = 1'b1;
                cmd.crc_step = 1'b1;
                if (stat.byte_last)
                begin
                    state_next = stat.ptr_last ? ST_FL_END : ST_FL_READ;
                end
            end
            ST_FL_END:
            begin
                cmd.emit_crc = 1'b1;
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: hdl/pscf_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pscf_datapath: parameter table, CRC engine and result register
// Table memory with per-slot valid bits (unwritten slots read as zero),
// flush pointer, byte counter, CRC register and the output word register.
// ----------------------------------------------------------------------------
module pscf_datapath
    import pscf_pkg::*;
#(
    parameter int PARAM_COUNT = PSCF_PARAM_COUNT
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire pscf_cmd_t   cmd,
    output pscf_stat_t       stat,
    input  wire logic [7:0]  param_index,
    input  wire logic [31:0] param_value,
    output logic             strobe,
    output logic             reply_kind,
    output logic [6:0]       word_index,
    output logic [31:0]      word_value,
    output logic             last_word
);

    localparam int IDX_W = (PARAM_COUNT > 1) ? $clog2(PARAM_COUNT) : 1;
    localparam int CNT_W = $clog2(PARAM_COUNT + 1);

    logic [31:0]            mem [PARAM_COUNT];
    logic [PARAM_COUNT-1:0] valid_reg;
    logic [PARAM_COUNT-1:0] valid_next;
    logic [31:0]            rd_data_reg;
    logic                   rd_valid_reg;
    logic [IDX_W-1:0]       wr_addr;
    logic [IDX_W-1:0]       rd_addr;
    logic [31:0]            rd_word;

    logic                   dirty_reg;
    logic                   dirty_next;
    logic [CNT_W-1:0]       ptr_reg;
    logic [CNT_W-1:0]       ptr_next;
    logic [1:0]             byte_reg;
    logic [1:0]             byte_next;
    logic [31:0]            crc_reg;
    logic [31:0]            crc_next;
    logic [IDX_W-1:0]       idx_reg;
    logic [IDX_W-1:0]       idx_next;

    logic                   strobe_reg;
    logic                   strobe_next;
    logic                   kind_reg;
    logic                   kind_next;
    logic [6:0]             windex_reg;
    logic [6:0]             windex_next;
    logic [31:0]            wvalue_reg;
    logic [31:0]            wvalue_next;
    logic                   last_reg;
    logic                   last_next;

    logic                   emit_data;

    assign wr_addr = param_index[IDX_W-1:0];
    assign rd_addr = cmd.use_ptr ? ptr_reg[IDX_W-1:0] : param_index[IDX_W-1:0];
    assign rd_word = rd_valid_reg ? rd_data_reg : 32'h0;

    always_ff @(posedge clk)
    begin
        if (cmd.save)
        begin
            mem[wr_addr] <= param_value;
        end
        rd_data_reg  <= mem[rd_addr];
        rd_valid_reg <= valid_reg[rd_addr];
    end

    assign stat.in_range  = {1'b0, param_index} < 9'(PARAM_COUNT);
    assign stat.dirty     = dirty_reg;
    assign stat.byte_last = (byte_reg == 2'd3);
    assign stat.ptr_last  = (ptr_reg == CNT_W'(PARAM_COUNT - 1));

    assign emit_data = cmd.crc_step && (byte_reg == 2'd0);

    always_comb
    begin
        valid_next  = valid_reg;
        dirty_next  = dirty_reg;
        ptr_next    = ptr_reg;
        byte_next   = byte_reg;
        crc_next    = crc_reg;
        idx_next    = idx_reg;
        strobe_next = cmd.load_emit | emit_data | cmd.emit_crc;
        kind_next   = kind_reg;
        windex_next = windex_reg;
        wvalue_next = wvalue_reg;
        last_next   = last_reg;

        if (cmd.save)
        begin
            valid_next[wr_addr] = 1'b1;
            dirty_next          = 1'b1;
        end
        if (cmd.load_cap)
        begin
            idx_next = param_index[IDX_W-1:0];
        end
        if (cmd.flush_init)
        begin
            dirty_next = 1'b0;
            ptr_next   = '0;
            byte_next  = 2'd0;
            crc_next   = CRC_INIT;
        end
        if (cmd.crc_step)
        begin
            crc_next  = crc_byte(crc_reg, rd_word[{byte_reg, 3'b000} +: 8]);
            byte_next = byte_reg + 2'd1;
            if (byte_reg == 2'd3)
            begin
                ptr_next = ptr_reg + CNT_W'(1);
            end
        end

        if (cmd.load_emit)
        begin
            kind_next   = REPLY_LOAD;
            windex_next = 7'(idx_reg);
            wvalue_next = rd_word;
            last_next   = 1'b1;
        end
        else if (emit_data)
        begin
            kind_next   = REPLY_IMAGE;
            windex_next = 7'(ptr_reg);
            wvalue_next = rd_word;
            last_next   = 1'b0;
        end
        else if (cmd.emit_crc)
        begin
            kind_next   = REPLY_IMAGE;
            windex_next = 7'(PARAM_COUNT);
            wvalue_next = ~crc_reg;
            last_next   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            dirty_reg  <= 1'b0;
            ptr_reg    <= '0;
            byte_reg   <= 2'd0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            dirty_reg  <= dirty_next;
            ptr_reg    <= ptr_next;
            byte_reg   <= byte_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        crc_reg    <= crc_next;
        idx_reg    <= idx_next;
        kind_reg   <= kind_next;
        windex_reg <= windex_next;
        wvalue_reg <= wvalue_next;
        last_reg   <= last_next;
    end

    assign strobe     = strobe_reg;
    assign reply_kind = kind_reg;
    assign word_index = windex_reg;
    assign word_value = wvalue_reg;
    assign last_word  = last_reg;

endmodule
`default_nettype wire

FILE: hdl/pscf_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pscf_checker: port-level checks for the parameter store
// Watches the command and result ports; attached to the top level by bind.
// ----------------------------------------------------------------------------
module pscf_checker
    import pscf_pkg::*;
#(
    parameter int PARAM_COUNT = PSCF_PARAM_COUNT
)
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic [1:0]  kind,
    input wire logic        strobe,
    input wire logic        reply_kind,
    input wire logic [6:0]  word_index,
    input wire logic        last_word
);

    // a load reply must follow an accepted load word, with ST_LOAD and the output register between them
    a_load_latency: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (reply_kind == REPLY_LOAD) |->
            $past(start && !busy && (kind == KIND_LOAD), 2))
        else $error("load reply without a load word two cycles earlier");

    a_load_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (reply_kind == REPLY_LOAD) |->
            last_word && (word_index < 7'(PARAM_COUNT)))
        else $error("load reply with bad slot or last flag");

    // the CRC word closes the image at position PARAM_COUNT
    a_crc_pos: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (reply_kind == REPLY_IMAGE) |->
            (last_word == (word_index == 7'(PARAM_COUNT))))
        else $error("image word position disagrees with last flag");

    // image words are emitted only while a flush holds the block busy
    a_image_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (reply_kind == REPLY_IMAGE) |-> $past(busy))
        else $error("image word outside a flush");

endmodule

bind param_store_crc32_flush pscf_checker #(
    .PARAM_COUNT (PARAM_COUNT)
) u_pscf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .kind       (kind),
    .strobe     (strobe),
    .reply_kind (reply_kind),
    .word_index (word_index),
    .last_word  (last_word)
);
`default_nettype wire

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for param_store_crc32_flush
// Drives save, load, flush tick and unused-kind words through the start/busy handshake.
// A shadow copy of the table and dirty bit predicts every load reply and
// flash image word, CRC included. Each strobed word is checked in order.
// ----------------------------------------------------------------------------
module tb;
    import pscf_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 60;

    typedef struct {
        logic        rk;
        logic [6:0]  idx;
        logic [31:0] val;
        logic        last;
    } store_reply_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [1:0]  kind = KIND_SAVE;
    logic [7:0]  param_index = 8'd0;
    logic [31:0] param_value = 32'd0;
    logic        busy;
    logic        strobe;
    logic        reply_kind;
    logic [6:0]  word_index;
    logic [31:0] word_value;
    logic        last_word;

    logic [31:0]  shadow_table [PSCF_PARAM_COUNT];
    logic         shadow_dirty;
    store_reply_t reply_q [$];
    int           mismatch_count = 0;
    int           idle_cycles = 0;
    bit           no_gaps = 1'b0;

    param_store_crc32_flush dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .kind        (kind),
        .param_index (param_index),
        .param_value (param_value),
        .strobe      (strobe),
        .reply_kind  (reply_kind),
        .word_index  (word_index),
        .word_value  (word_value),
        .last_word   (last_word)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        for (int s = 0; s < PSCF_PARAM_COUNT; s++)
            shadow_table[s] = 32'd0;
        shadow_dirty = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t ERROR: %s", $time, msg);
        mismatch_count++;
    endtask

    // update the shadow store with one accepted word and queue its replies
    function automatic void predict_store(input logic [1:0] k, input logic [7:0] idx,
                                          input logic [31:0] val);
        store_reply_t r;
        logic [31:0]  crc;
        logic         fb;
        case (k)
            KIND_SAVE:
            begin
                if (idx < PSCF_PARAM_COUNT)
                begin
                    shadow_table[idx] = val;
                    shadow_dirty = 1'b1;
                end
            end
            KIND_LOAD:
            begin
                if (idx < PSCF_PARAM_COUNT)
                begin
                    r = '{REPLY_LOAD, idx[6:0], shadow_table[idx], 1'b1};
                    reply_q.push_back(r);
                end
            end
            KIND_TICK:
            begin
                if (shadow_dirty)
                begin
                    shadow_dirty = 1'b0;
                    crc = CRC_INIT;
                    for (int s = 0; s < PSCF_PARAM_COUNT; s++)
                    begin
                        // bit-serial reflected CRC; LSB first equals LE bytes
                        for (int b = 0; b < 32; b++)
                        begin
                            fb = crc[0] ^ shadow_table[s][b];
                            crc = crc >> 1;
                            if (fb)
                                crc = crc ^ CRC_POLY;
                        end
                        r = '{REPLY_IMAGE, 7'(s), shadow_table[s], 1'b0};
                        reply_q.push_back(r);
                    end
                    r = '{REPLY_IMAGE, 7'(PSCF_PARAM_COUNT), ~crc, 1'b1};
                    reply_q.push_back(r);
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    // check first: a reply on this edge always belongs to an older word
    always @(posedge clk)
    begin : check_replies
        store_reply_t want;
        if (rst_n)
        begin
            if (strobe)
            begin
                if (reply_q.size() == 0)
                    report_mismatch($sformatf("unexpected word kind=%0d idx=%0d val=%h",
                                              reply_kind, word_index, word_value));
                else
                begin
                    want = reply_q.pop_front();
                    if (reply_kind !== want.rk)
                        report_mismatch($sformatf("reply_kind %0d, want %0d",
                                                  reply_kind, want.rk));
                    if (word_index !== want.idx)
                        report_mismatch($sformatf("word_index %0d, want %0d",
                                                  word_index, want.idx));
                    if (word_value !== want.val)
                        report_mismatch($sformatf("word_value %h, want %h (idx %0d)",
                                                  word_value, want.val, want.idx));
                    if (last_word !== want.last)
                        report_mismatch($sformatf("last_word %0d, want %0d (idx %0d)",
                                                  last_word, want.last, want.idx));
                end
            end
            if (start && !busy)
                predict_store(kind, param_index, param_value);
            if (strobe || (start && !busy))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // present one word, with an optional random gap first; returns at acceptance
    task automatic send_word(input logic [1:0] k, input logic [7:0] idx,
                             input logic [31:0] val);
        int gap;
        gap = 0;
        if (!no_gaps && $urandom_range(99) < 8)
            gap = ($urandom_range(9) == 0) ? $urandom_range(7, 45) : $urandom_range(1, 6);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        kind        <= k;
        param_index <= idx;
        param_value <= val;
        do
            @(posedge clk);
        while (busy !== 1'b0);
    endtask

    task automatic test_reset_state();
        send_word(KIND_LOAD, 8'd0, 32'hDEAD_BEEF);
        send_word(KIND_LOAD, 8'(PSCF_PARAM_COUNT - 1), 32'd0);
        send_word(KIND_TICK, 8'd0, 32'd0);
    endtask

    task automatic test_out_of_range();
        send_word(KIND_SAVE, 8'(PSCF_PARAM_COUNT), 32'h1234_5678);
        send_word(KIND_SAVE, 8'hFF, 32'hFFFF_FFFF);
        send_word(KIND_LOAD, 8'(PSCF_PARAM_COUNT), 32'd0);
        send_word(KIND_LOAD, 8'hFF, 32'hFFFF_FFFF);
        // table must still be clean
        send_word(KIND_TICK, 8'hFF, 32'hFFFF_FFFF);
    endtask

    task automatic test_unused_kind();
        send_word(KIND_UNUSED, 8'd0, 32'hFFFF_FFFF);
        send_word(KIND_UNUSED, 8'hFF, 32'h0);
        send_word(KIND_LOAD, 8'd0, 32'd0);
    endtask

    task automatic test_flush_image();
        send_word(KIND_SAVE, 8'd0, 32'hFFFF_FFFF);
        send_word(KIND_SAVE, 8'(PSCF_PARAM_COUNT - 1), 32'h8000_0001);
        send_word(KIND_SAVE, 8'd3, 32'hA5A5_A5A5);
        send_word(KIND_LOAD, 8'd0, 32'd0);
        send_word(KIND_LOAD, 8'(PSCF_PARAM_COUNT - 1), 32'd0);
        send_word(KIND_TICK, 8'd0, 32'd0);
        send_word(KIND_TICK, 8'd0, 32'd0);
        send_word(KIND_LOAD, 8'd3, 32'd0);
    endtask

    task automatic test_resave_zero();
        send_word(KIND_SAVE, 8'd0, 32'd0);
        send_word(KIND_TICK, 8'h5A, 32'h0F0F_0F0F);
    endtask

    task automatic test_random(input int target);
        int          sel;
        int          sent;
        logic [31:0] val;
        sent = 0;
        while (sent < target)
        begin
            no_gaps = (sent >= 150 && sent < 250);
            sel = $urandom_range(99);
            val = $urandom;
            if ($urandom_range(9) == 0)
                val = $urandom_range(1) ? 32'hFFFF_FFFF : 32'd0;
            if (sel < 45)
                send_word(KIND_SAVE, 8'($urandom_range(PSCF_PARAM_COUNT - 1)), val);
            else if (sel < 75)
                send_word(KIND_LOAD, 8'($urandom_range(PSCF_PARAM_COUNT - 1)), val);
            else if (sel < 88)
                send_word(KIND_TICK, 8'($urandom_range(255)), val);
            else if (sel < 95)
                send_word($urandom_range(1) ? KIND_SAVE : KIND_LOAD,
                          8'($urandom_range(255, PSCF_PARAM_COUNT)), val);
            else
                send_word(KIND_UNUSED, 8'($urandom_range(255)), val);
            sent++;
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_out_of_range();
        test_unused_kind();
        test_flush_image();
        test_resave_zero();
        test_random(390);
        start <= 1'b0;
        while (reply_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && reply_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
